// File: rtl/core/ihex_pkg.sv
// ihex_pkg: shared types, codes and the hex digit decoder of the hex record parser
// depends on nothing; imported by intel_hex_record_parser
`default_nettype none

package ihex_pkg;

    localparam int CHAR_W     = 8;
    localparam int POS_W      = 10;
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 32;
    localparam int HALF_W     = 16;
    localparam int STATUS_W   = 4;
    localparam int OUT_DATA_W = 72;

    localparam logic [CHAR_W-1:0] CHAR_COLON   = 8'h3A;
    localparam logic [POS_W-1:0]  POS_MAX      = 10'd1023;
    localparam logic [POS_W-1:0]  MIN_LINE_LEN = 10'd11;

    localparam logic [BYTE_W-1:0] REC_DATA    = 8'h00;
    localparam logic [BYTE_W-1:0] REC_EXT_LIN = 8'h04;
    localparam logic [BYTE_W-1:0] EXT_LEN     = 8'h02;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 4'd0,
        ST_NO_COLON    = 4'd1,
        ST_SHORT       = 4'd2,
        ST_BAD_LEN     = 4'd3,
        ST_BAD_ADDR    = 4'd4,
        ST_BAD_DATA    = 4'd5,
        ST_BAD_CSUM_DG = 4'd6,
        ST_CSUM        = 4'd7,
        ST_EXT_LEN     = 4'd8,
        ST_TYPE        = 4'd9
    } t_status;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_digit;

    function automatic t_digit hex_digit(input logic [CHAR_W-1:0] c);
        t_digit d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            d.value = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            d.value = 4'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            d.value = 4'(c - 8'h37);
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/intel_hex_record_parser.sv
// intel_hex_record_parser: one character a word, decodes hex records into data bytes and status
// result word registered from the accepted character; 1 character per cycle unless stalled
// the line state registers and one output register hold everything, set by a single decode pass
// a new character is taken whenever the output register is empty or being drained
// synchronous active-low reset clears line state, both address halves and the output valid
// depends on ihex_pkg
`default_nettype none

module intel_hex_record_parser
    import ihex_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [CHAR_W-1:0]     s_axis_tdata,   // char_in
    input  wire logic                  s_axis_tlast,   // end_of_line
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // data_byte, byte_address, byte_index, record_type, status, data_count, zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tuser    // result_kind
);

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [3:0]        r_hi, n_hi;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [HALF_W-1:0] r_addr_lo, n_addr_lo;
    logic [HALF_W-1:0] r_addr_hi, n_addr_hi;
    logic [BYTE_W-1:0] r_dpos, n_dpos;
    logic [HALF_W-1:0] r_ext, n_ext;
    t_status           r_err, n_err;

    logic                  r_valid;
    logic [OUT_DATA_W-1:0] r_data, n_data;
    logic                  r_kind, n_kind;

    logic                  accept;
    logic                  emit;
    logic [POS_W-1:0]      pos_m1;
    logic [8:0]            k;
    logic [8:0]            lim;
    logic                  in_field;
    t_digit                dg;
    logic [BYTE_W-1:0]     b;
    t_status               st;
    logic [ADDR_W-1:0]     addr;
    logic [POS_W-1:0]      need_len;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = r_kind;

    assign pos_m1   = r_pos - 10'd1;
    assign k        = pos_m1[POS_W-1:1];
    assign lim      = {1'b0, r_len} + 9'd4;
    assign in_field = (k == 9'd0) || (k <= lim);
    assign dg       = hex_digit(s_axis_tdata);
    assign b        = {r_hi, dg.value};
    assign addr     = {r_addr_hi, r_addr_lo} + {{(ADDR_W-BYTE_W){1'b0}}, r_dpos};

    always_comb begin
        n_pos     = (r_pos != POS_MAX) ? r_pos + 10'd1 : r_pos;
        n_hi      = r_hi;
        n_len     = r_len;
        n_sum     = r_sum;
        n_type    = r_type;
        n_addr_lo = r_addr_lo;
        n_addr_hi = r_addr_hi;
        n_dpos    = r_dpos;
        n_ext     = r_ext;
        n_err     = r_err;
        emit      = 1'b0;
        n_kind    = KIND_DATA;
        n_data    = '0;
        st        = ST_OK;
        need_len  = '0;

        if (r_pos == '0) begin
            if (s_axis_tdata != CHAR_COLON) begin
                n_err = ST_NO_COLON;
            end
        end else if (r_err == ST_OK && in_field) begin
            if (!dg.valid) begin
                if (k == 9'd0) begin
                    n_err = ST_BAD_LEN;
                end else if (k <= 9'd2) begin
                    n_err = ST_BAD_ADDR;
                end else if (k < lim) begin
                    n_err = ST_BAD_DATA;
                end else begin
                    n_err = ST_BAD_CSUM_DG;
                end
            end else if (r_pos[0]) begin
                n_hi = dg.value;
            end else begin
                n_sum = r_sum + b;
                if (k == 9'd0) begin
                    n_len = b;
                end else if (k == 9'd1) begin
                    n_addr_lo[15:8] = b;
                end else if (k == 9'd2) begin
                    n_addr_lo[7:0] = b;
                end else if (k == 9'd3) begin
                    n_type = b;
                end else if (k < lim) begin
                    if (r_dpos < 8'd2) begin
                        n_ext = {r_ext[7:0], b};
                    end
                    if (!s_axis_tlast) begin
                        emit   = 1'b1;
                        n_kind = KIND_DATA;
                        n_data = {4'd0, r_len, ST_OK, r_type, r_dpos, addr, b};
                    end
                    n_dpos = r_dpos + 8'd1;
                end
            end
        end

        if (s_axis_tlast) begin
            need_len = MIN_LINE_LEN + {1'b0, n_len, 1'b0};
            if (n_err == ST_NO_COLON) begin
                st = ST_NO_COLON;
            end else if (n_pos < MIN_LINE_LEN) begin
                st = ST_SHORT;
            end else if (n_err == ST_BAD_LEN) begin
                st = ST_BAD_LEN;
            end else if (n_pos < need_len) begin
                st = ST_SHORT;
            end else if (n_err != ST_OK) begin
                st = n_err;
            end else if (n_sum != 8'd0) begin
                st = ST_CSUM;
            end else if (n_type == REC_DATA) begin
                st = ST_OK;
            end else if (n_type == REC_EXT_LIN) begin
                if (n_len != EXT_LEN) begin
                    st = ST_EXT_LEN;
                end else begin
                    st        = ST_OK;
                    n_addr_hi = n_ext;
                end
            end else begin
                st = ST_TYPE;
            end

            emit   = 1'b1;
            n_kind = KIND_STATUS;
            n_data = {4'd0, (st == ST_OK) ? n_len : 8'd0, st, n_type, 8'd0,
                      {ADDR_W{1'b0}}, 8'd0};

            n_pos  = '0;
            n_hi   = '0;
            n_len  = '0;
            n_sum  = '0;
            n_type = '0;
            n_dpos = '0;
            n_ext  = '0;
            n_err  = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_hi      <= '0;
            r_len     <= '0;
            r_sum     <= '0;
            r_type    <= '0;
            r_addr_lo <= '0;
            r_addr_hi <= '0;
            r_dpos    <= '0;
            r_ext     <= '0;
            r_err     <= ST_OK;
            r_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_pos     <= n_pos;
                r_hi      <= n_hi;
                r_len     <= n_len;
                r_sum     <= n_sum;
                r_type    <= n_type;
                r_addr_lo <= n_addr_lo;
                r_addr_hi <= n_addr_hi;
                r_dpos    <= n_dpos;
                r_ext     <= n_ext;
                r_err     <= n_err;
            end
            if (s_axis_tready) begin
                r_valid <= accept && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_data <= n_data;
            r_kind <= n_kind;
        end
    end

    a_eol_clears_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tlast |=> r_pos == '0 && r_err == ST_OK)
        else $error("line state not cleared after end of line");

    a_pos_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !s_axis_tlast |=> r_pos != '0)
        else $error("character position did not advance");

    a_eol_gives_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tlast |=> m_axis_tvalid && m_axis_tuser == KIND_STATUS)
        else $error("no status word at end of line");

    a_no_data_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !s_axis_tlast && r_pos != '0 && r_err != ST_OK |=> !m_axis_tvalid)
        else $error("word emitted on a line with an error");

endmodule

`default_nettype wire

// File: sim/tb_intel_hex_record_parser.sv
// testbench for intel_hex_record_parser: drives hex record lines one character a word
// and checks every data byte and line status against a cycle-free predictor of the parser
// depends on ihex_pkg and intel_hex_record_parser
`timescale 1ns / 100ps

module tb_intel_hex_record_parser
    import ihex_pkg::*;
;

    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] idx;
        logic [BYTE_W-1:0] rtype;
        t_status           status;
        logic [BYTE_W-1:0] count;
    } t_hex_word;

    class t_hex_record_tracker;
        logic [POS_W-1:0]  char_pos;
        logic [3:0]        hi_nib;
        logic [BYTE_W-1:0] rec_len;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] rec_type;
        logic [BYTE_W-1:0] data_pos;
        logic [HALF_W-1:0] addr_lo;
        logic [HALF_W-1:0] addr_hi;
        logic [HALF_W-1:0] ext_word;
        t_status           line_err;
        t_hex_word         expected_words[$];
        int                errors;
        int                data_seen;
        int                status_seen;
        int                clean_seen;

        function new();
            errors      = 0;
            data_seen   = 0;
            status_seen = 0;
            clean_seen  = 0;
            addr_lo     = '0;
            addr_hi     = '0;
            clear_line();
        endfunction

        function void clear_line();
            char_pos = '0;
            hi_nib   = '0;
            rec_len  = '0;
            sum      = '0;
            rec_type = '0;
            data_pos = '0;
            ext_word = '0;
            line_err = ST_OK;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function bit decode_digit(input logic [7:0] c, output logic [3:0] v);
            v = 4'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                v = 4'(c - 8'h30);
                return 1'b1;
            end
            if (c >= 8'h61 && c <= 8'h66) begin
                v = 4'(c - 8'h61 + 8'd10);
                return 1'b1;
            end
            if (c >= 8'h41 && c <= 8'h46) begin
                v = 4'(c - 8'h41 + 8'd10);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // one accepted character: push the data byte or line status it causes
        function void note_char(input logic [7:0] c, input logic eol);
            logic [POS_W-1:0]  pos;
            logic [3:0]        nib;
            logic [BYTE_W-1:0] b;
            logic [BYTE_W-1:0] idx;
            t_hex_word         r;
            t_status           st;
            int                k;
            int                n;
            pos = char_pos;
            if (pos == 0) begin
                if (c != CHAR_COLON) line_err = ST_NO_COLON;
            end else if (line_err == ST_OK) begin
                k = (int'(pos) - 1) >> 1;
                if (k <= 4 + int'(rec_len)) begin
                    if (!decode_digit(c, nib)) begin
                        if (k == 0) line_err = ST_BAD_LEN;
                        else if (k <= 2) line_err = ST_BAD_ADDR;
                        else if (k < 4 + int'(rec_len)) line_err = ST_BAD_DATA;
                        else line_err = ST_BAD_CSUM_DG;
                    end else if (pos[0]) begin
                        hi_nib = nib;
                    end else begin
                        b = {hi_nib, nib};
                        sum = sum + b;
                        if (k == 0) begin
                            rec_len = b;
                        end else if (k == 1) begin
                            addr_lo[15:8] = b;
                        end else if (k == 2) begin
                            addr_lo[7:0] = b;
                        end else if (k == 3) begin
                            rec_type = b;
                        end else if (k < 4 + int'(rec_len)) begin
                            idx = data_pos;
                            if (idx < 2) ext_word = {ext_word[7:0], b};
                            // a byte completed on the last character is dropped
                            if (!eol) begin
                                r           = '0;
                                r.kind      = KIND_DATA;
                                r.data_byte = b;
                                r.addr      = {addr_hi, addr_lo} + ADDR_W'(idx);
                                r.idx       = idx;
                                r.rtype     = rec_type;
                                r.status    = ST_OK;
                                r.count     = rec_len;
                                expected_words.push_back(r);
                            end
                            data_pos = idx + 8'd1;
                        end
                    end
                end
            end

            char_pos = (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;

            if (eol) begin
                n = int'(char_pos);
                if (line_err == ST_NO_COLON) st = ST_NO_COLON;
                else if (n < int'(MIN_LINE_LEN)) st = ST_SHORT;
                else if (line_err == ST_BAD_LEN) st = ST_BAD_LEN;
                else if (n < int'(MIN_LINE_LEN) + 2 * int'(rec_len)) st = ST_SHORT;
                else if (line_err != ST_OK) st = line_err;
                else if (sum != 0) st = ST_CSUM;
                else if (rec_type == REC_DATA) st = ST_OK;
                else if (rec_type == REC_EXT_LIN) begin
                    if (rec_len != EXT_LEN) begin
                        st = ST_EXT_LEN;
                    end else begin
                        st = ST_OK;
                        addr_hi = ext_word;
                    end
                end else st = ST_TYPE;
                r        = '0;
                r.kind   = KIND_STATUS;
                r.rtype  = rec_type;
                r.status = st;
                r.count  = (st == ST_OK) ? rec_len : '0;
                expected_words.push_back(r);
                clear_line();
            end
        endfunction

        task report_mismatch(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(input string name, input logic [31:0] got,
                           input logic [31:0] want);
            if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        endtask

        task check_word(input logic kind, input logic [OUT_DATA_W-1:0] w);
            t_hex_word got;
            t_hex_word want;
            got.kind      = kind;
            got.data_byte = w[7:0];
            got.addr      = w[39:8];
            got.idx       = w[47:40];
            got.rtype     = w[55:48];
            got.status    = t_status'(w[59:56]);
            got.count     = w[67:60];
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h kind %b", w, kind));
                return;
            end
            want = expected_words.pop_front();
            compare_field("kind", 32'(got.kind), 32'(want.kind));
            compare_field("data_byte", 32'(got.data_byte), 32'(want.data_byte));
            compare_field("byte_address", got.addr, want.addr);
            compare_field("byte_index", 32'(got.idx), 32'(want.idx));
            compare_field("record_type", 32'(got.rtype), 32'(want.rtype));
            compare_field("status", 32'(got.status), 32'(want.status));
            compare_field("data_count", 32'(got.count), 32'(want.count));
            if (want.kind == KIND_DATA) begin
                data_seen++;
            end else begin
                status_seen++;
                if (want.status == ST_OK) clean_seen++;
            end
        endtask
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [CHAR_W-1:0]     s_axis_tdata  = '0;    // char_in
    logic                  s_axis_tlast  = 1'b0;  // end_of_line
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // data_byte, byte_address, byte_index, record_type, status, data_count, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;          // result_kind

    t_hex_record_tracker tracker = new();
    int                tx_idle_pct  = 0;
    int                rx_stall_pct = 0;
    int                sent_chars   = 0;
    int                sent_lines   = 0;
    int                quiet_cycles = 0;

    intel_hex_record_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) tracker.check_word(m_axis_tuser, m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic void put_byte(ref logic [7:0] q[$], input logic [7:0] b);
        q.push_back(hex_ascii(b[7:4]));
        q.push_back(hex_ascii(b[3:0]));
    endfunction

    // lead gives the first two data bytes, the rest are random
    function automatic void build_record(ref logic [7:0] q[$], input int len,
                                         input logic [15:0] addr, input logic [7:0] rtype,
                                         input logic [15:0] lead, input bit good_sum);
        logic [7:0] sum;
        logic [7:0] b;
        q.delete();
        q.push_back(CHAR_COLON);
        sum = 8'(len) + addr[15:8] + addr[7:0] + rtype;
        put_byte(q, 8'(len));
        put_byte(q, addr[15:8]);
        put_byte(q, addr[7:0]);
        put_byte(q, rtype);
        for (int i = 0; i < len; i++) begin
            b = (i == 0) ? lead[15:8] : (i == 1) ? lead[7:0] : 8'($urandom_range(255));
            sum = sum + b;
            put_byte(q, b);
        end
        put_byte(q, good_sum ? 8'd0 - sum : sum + 8'($urandom_range(1, 255)));
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_char(c, last);
        sent_chars++;
        @(negedge i_clk);
    endtask

    task automatic send_line(ref logic [7:0] q[$]);
        for (int i = 0; i < q.size(); i++) send_char(q[i], i == q.size() - 1);
        sent_lines++;
    endtask

    task automatic wait_drained();
        do begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end while (tracker.pending() != 0);
    endtask

    initial begin
        logic [7:0] line[$];
        logic [7:0] rt;
        int         roll;
        int         sel;
        int         len;
        int         stop_at;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines
        build_record(line, 3, 16'h1000, REC_DATA, 16'hA55A, 1);
        send_line(line);
        build_record(line, 2, 16'h0000, REC_EXT_LIN, 16'hFFFF, 1);
        send_line(line);
        // upper half ffff, low address near the top: byte address wraps
        build_record(line, 4, 16'hFFFE, REC_DATA, 16'h00FF, 1);
        send_line(line);
        build_record(line, 0, 16'h0000, REC_DATA, 16'h0000, 1);
        send_line(line);
        build_record(line, 0, 16'h0000, 8'h01, 16'h0000, 1);
        send_line(line);
        build_record(line, 2, 16'h0040, 8'h02, 16'hBEEF, 1);
        send_line(line);
        build_record(line, 1, 16'h0000, REC_EXT_LIN, 16'h7700, 1);
        send_line(line);
        build_record(line, 2, 16'h1234, REC_DATA, 16'h0102, 0);
        send_line(line);
        build_record(line, 2, 16'h1234, REC_DATA, 16'h0102, 1);
        line[0] = 8'h58;
        send_line(line);
        line = {CHAR_COLON, 8'h31, 8'h30};
        send_line(line);
        build_record(line, 2, 16'h2000, REC_DATA, 16'h1122, 1);
        line[1] = 8'h47;
        send_line(line);
        build_record(line, 2, 16'h2000, REC_DATA, 16'h1122, 1);
        line[5] = 8'h67;
        send_line(line);
        build_record(line, 2, 16'h2000, REC_DATA, 16'h1122, 1);
        line[10] = 8'h20;
        send_line(line);
        build_record(line, 2, 16'h2000, REC_DATA, 16'h1122, 1);
        line[line.size() - 1] = 8'h2B;
        send_line(line);
        // line ends on the second digit of a data byte
        build_record(line, 4, 16'h3000, REC_DATA, 16'h3344, 1);
        line = line[0:12];
        send_line(line);
        // longest record, then trailing characters past the position counter's top
        build_record(line, 255, 16'hFF80, REC_DATA, 16'h0000, 1);
        repeat (520) line.push_back(8'h78);
        send_line(line);
        build_record(line, 2, 16'h0000, REC_EXT_LIN, 16'h0000, 1);
        send_line(line);
        line = {CHAR_COLON};
        send_line(line);
        line = {8'hFF};
        send_line(line);

        for (int phase = 0; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 70;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 70;
                end
                default: begin
                    tx_idle_pct  = 37;
                    rx_stall_pct = 37;
                end
            endcase
            stop_at = sent_chars + 60;
            while (sent_chars < stop_at) begin
                roll = $urandom_range(99);
                if (roll < 70) begin
                    sel = $urandom_range(99);
                    len = ($urandom_range(99) < 3) ? $urandom_range(17, 255) : $urandom_range(0, 16);
                    if (sel < 60) begin
                        rt = REC_DATA;
                    end else if (sel < 80) begin
                        rt  = REC_EXT_LIN;
                        len = int'(EXT_LEN);
                    end else if (sel < 90) begin
                        rt = REC_EXT_LIN;
                    end else begin
                        rt = 8'($urandom_range(255));
                    end
                    build_record(line, len, 16'($urandom_range(16'hFFFF)), rt,
                                 16'($urandom_range(16'hFFFF)), $urandom_range(9) != 0);
                    if ($urandom_range(99) < 25) begin
                        case ($urandom_range(2))
                            0: line[$urandom_range(line.size() - 1)] = 8'($urandom_range(255));
                            1: line = line[0:$urandom_range(line.size() - 1)];
                            default: repeat ($urandom_range(1, 6)) line.push_back(8'($urandom_range(255)));
                        endcase
                    end
                end else if (roll < 85) begin
                    line.delete();
                    repeat ($urandom_range(1, 24)) line.push_back(8'($urandom_range(255)));
                end else begin
                    line = {CHAR_COLON};
                    repeat ($urandom_range(0, 30)) begin
                        line.push_back($urandom_range(1) ? hex_ascii(4'($urandom_range(15)))
                                                         : 8'($urandom_range(255)));
                    end
                end
                send_line(line);
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("sent %0d lines in %0d characters under four pacing phases", sent_lines, sent_chars);
        $display("checked %0d data bytes and %0d line statuses, %0d of them clean",
                 tracker.data_seen, tracker.status_seen, tracker.clean_seen);
        if (tracker.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
